// ===== design/htbp_pkg.sv =====
// htbp_pkg: shared constants, codes and small types of the block-probe hash table
// no dependencies; used by every other file of the block but htbp_ram
package htbp_pkg;

   // fixed field widths
   localparam int HASH_WIDTH  = 32;
   localparam int SLOTS       = 8;
   localparam int SLOT_W      = 3;
   localparam int STATUS_W    = 8;
   localparam logic [STATUS_W-1:0] EMPTY_MARK = 8'h80;

   // defaults of the top level parameters
   localparam int LOG_BLOCKS_MAX_DEF = 10;
   localparam int GROUP_ID_WIDTH_DEF = 25;
   localparam int HASH_BITS_DEF      = 32;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_BLOCKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STAMP_BITS = 2'd1;
   localparam int LOG_BLOCKS_CFG_W = 4;
   localparam int STAMP_BITS_CFG_W = 3;
   localparam logic [LOG_BLOCKS_CFG_W-1:0] LOG_BLOCKS_RESET = 4'd0;
   localparam logic [STAMP_BITS_CFG_W-1:0] STAMP_BITS_RESET = 3'd7;

   // buffering between and behind the two halves
   localparam int QUEUE_DEPTH = 4;
   localparam int OFIFO_DEPTH = 4;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_WRITE  = 1'b1
   } op_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // a block index needs at least one bit even with a single block
   function automatic int block_width(input int log_blocks_max);
      return (log_blocks_max > 0) ? log_blocks_max : 1;
   endfunction

   // op, row, slot, key byte, group, batch end
   function automatic int entry_width(input int bw, input int gw);
      return 1 + bw + SLOT_W + STATUS_W + gw + 1;
   endfunction

endpackage

// ===== design/htbp_ifs.sv =====
// htbp channel interfaces: request, response and register write channels
// depends on htbp_pkg
interface htbp_req_if #(
   parameter int LOG_BLOCKS_MAX = htbp_pkg::LOG_BLOCKS_MAX_DEF,
   parameter int GROUP_ID_WIDTH = htbp_pkg::GROUP_ID_WIDTH_DEF
);
   localparam int BLOCK_W = htbp_pkg::block_width(LOG_BLOCKS_MAX);

   logic                              valid;
   logic                              ready;
   logic                              cmd;
   logic [htbp_pkg::HASH_WIDTH-1:0]   hash;
   logic [BLOCK_W-1:0]                block_index;
   logic [htbp_pkg::SLOT_W-1:0]       slot_index;
   logic [htbp_pkg::STATUS_W-1:0]     slot_status;
   logic [GROUP_ID_WIDTH-1:0]         group_value;
   logic                              last_in_batch;

   modport source (output valid, cmd, hash, block_index, slot_index, slot_status,
                   group_value, last_in_batch, input ready);
   modport sink   (input valid, cmd, hash, block_index, slot_index, slot_status,
                   group_value, last_in_batch, output ready);
endinterface

interface htbp_rsp_if #(
   parameter int LOG_BLOCKS_MAX = htbp_pkg::LOG_BLOCKS_MAX_DEF,
   parameter int GROUP_ID_WIDTH = htbp_pkg::GROUP_ID_WIDTH_DEF
);
   localparam int NEXT_W = htbp_pkg::block_width(LOG_BLOCKS_MAX) + 4;

   logic                      valid;
   logic                      ready;
   logic                      match_found;
   logic [GROUP_ID_WIDTH-1:0] group_id;
   logic [NEXT_W-1:0]         next_slot;
   logic                      batch_end;

   modport source (output valid, match_found, group_id, next_slot, batch_end,
                   input ready);
   modport sink   (input valid, match_found, group_id, next_slot, batch_end,
                   output ready);
endinterface

interface htbp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [htbp_pkg::CSR_INDEX_W-1:0]   index;
   logic [htbp_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/htbp_ram.sv =====
// htbp_ram: generic single write port ram with registered read
// no dependencies
module htbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/htbp_queue.sv =====
// htbp_queue: small fifo of decoded words between front and back
// depends on htbp_pkg for the status struct
module htbp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = htbp_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [WIDTH-1:0]    push_data,
   input  logic                pop,
   output logic [WIDTH-1:0]    pop_data,
   output htbp_pkg::qstat_type stat
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));
endmodule

// ===== design/htbp_front.sv =====
// htbp_front: register file, request accept and decode of hash into block and stamp
// depends on htbp_pkg and htbp_ifs
module htbp_front #(
   parameter int LOG_BLOCKS_MAX = htbp_pkg::LOG_BLOCKS_MAX_DEF,
   parameter int GROUP_ID_WIDTH = htbp_pkg::GROUP_ID_WIDTH_DEF,
   parameter int HASH_BITS      = htbp_pkg::HASH_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   htbp_req_if.sink            req_bus,
   htbp_csr_if.sink            csr_bus,
   input  htbp_pkg::qstat_type q_stat,
   input  logic                clr_busy,
   output logic                push,
   output logic [htbp_pkg::entry_width(htbp_pkg::block_width(LOG_BLOCKS_MAX),
                                        GROUP_ID_WIDTH)-1:0] push_data
);
   localparam int BLOCK_W = htbp_pkg::block_width(LOG_BLOCKS_MAX);
   localparam logic [htbp_pkg::HASH_WIDTH-1:0] HASH_MASK =
      htbp_pkg::HASH_WIDTH'((64'd1 << HASH_BITS) - 64'd1);

   typedef struct packed {
      htbp_pkg::op_type                op;
      logic [BLOCK_W-1:0]              row;
      logic [htbp_pkg::SLOT_W-1:0]     slot;
      logic [htbp_pkg::STATUS_W-1:0]   key;
      logic [GROUP_ID_WIDTH-1:0]       grp;
      logic                            last;
   } entry_type;

   logic [htbp_pkg::LOG_BLOCKS_CFG_W-1:0] log_blocks_ff, log_blocks_in;
   logic [htbp_pkg::STAMP_BITS_CFG_W-1:0] stamp_bits_ff, stamp_bits_in;

   logic [4:0]                       lb;
   logic [5:0]                       used;
   logic [5:0]                       shift;
   logic [htbp_pkg::HASH_WIDTH-1:0]  hv;
   logic [htbp_pkg::HASH_WIDTH-1:0]  blk_all;
   logic [htbp_pkg::HASH_WIDTH-1:0]  blk_mask;
   logic [htbp_pkg::STATUS_W-1:0]    stamp_mask;
   entry_type                        entry;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      log_blocks_in = log_blocks_ff;
      stamp_bits_in = stamp_bits_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            htbp_pkg::CSR_LOG_BLOCKS: begin
               log_blocks_in = csr_bus.data;
            end
            htbp_pkg::CSR_STAMP_BITS: begin
               stamp_bits_in = csr_bus.data[htbp_pkg::STAMP_BITS_CFG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_blocks_ff <= htbp_pkg::LOG_BLOCKS_RESET;
         stamp_bits_ff <= htbp_pkg::STAMP_BITS_RESET;
      end else begin
         log_blocks_ff <= log_blocks_in;
         stamp_bits_ff <= stamp_bits_in;
      end
   end

   // hash split: block above stamp, both taken from the top of the used bits
   always_comb begin
      lb = ({1'b0, log_blocks_ff} > 5'(LOG_BLOCKS_MAX)) ? 5'(LOG_BLOCKS_MAX)
                                                         : {1'b0, log_blocks_ff};
      used       = {1'b0, lb} + {3'b000, stamp_bits_ff};
      shift      = (used > 6'(HASH_BITS)) ? 6'd0 : 6'(HASH_BITS) - used;
      hv         = (req_bus.hash & HASH_MASK) >> shift;
      stamp_mask = htbp_pkg::STATUS_W'((9'd1 << stamp_bits_ff) - 9'd1);
      blk_all    = hv >> stamp_bits_ff;
      blk_mask   = htbp_pkg::HASH_WIDTH'((33'd1 << lb) - 33'd1);

      if (req_bus.cmd) begin
         entry.op   = htbp_pkg::OP_WRITE;
         entry.row  = req_bus.block_index;
         entry.slot = req_bus.slot_index;
         entry.key  = req_bus.slot_status;
         entry.grp  = req_bus.group_value;
      end else begin
         entry.op   = htbp_pkg::OP_LOOKUP;
         entry.row  = BLOCK_W'(blk_all & blk_mask);
         entry.slot = '0;
         entry.key  = hv[htbp_pkg::STATUS_W-1:0] & stamp_mask;
         entry.grp  = '0;
      end
      entry.last = req_bus.last_in_batch;
   end

   assign req_bus.ready = !q_stat.full && !clr_busy;
   assign push          = req_bus.valid && req_bus.ready;
   assign push_data     = entry;
endmodule

// ===== design/htbp_back.sv =====
// htbp_back: clearing pass, slot memories, parallel stamp compare and result buffer
// depends on htbp_pkg, htbp_ifs and htbp_ram
module htbp_back #(
   parameter int LOG_BLOCKS_MAX = htbp_pkg::LOG_BLOCKS_MAX_DEF,
   parameter int GROUP_ID_WIDTH = htbp_pkg::GROUP_ID_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  htbp_pkg::qstat_type q_stat,
   input  logic [htbp_pkg::entry_width(htbp_pkg::block_width(LOG_BLOCKS_MAX),
                                        GROUP_ID_WIDTH)-1:0] q_data,
   output logic                pop,
   output logic                clr_busy,
   htbp_rsp_if.source          rsp_bus
);
   localparam int BLOCK_W = htbp_pkg::block_width(LOG_BLOCKS_MAX);
   localparam int ROWS    = 2 ** BLOCK_W;
   localparam int NEXT_W  = BLOCK_W + 4;
   localparam int OPW     = $clog2(htbp_pkg::OFIFO_DEPTH);
   localparam int OCW     = $clog2(htbp_pkg::OFIFO_DEPTH + 1);

   typedef struct packed {
      htbp_pkg::op_type                op;
      logic [BLOCK_W-1:0]              row;
      logic [htbp_pkg::SLOT_W-1:0]     slot;
      logic [htbp_pkg::STATUS_W-1:0]   key;
      logic [GROUP_ID_WIDTH-1:0]       grp;
      logic                            last;
   } entry_type;

   typedef struct packed {
      logic                            match_found;
      logic [GROUP_ID_WIDTH-1:0]       group_id;
      logic [NEXT_W-1:0]               next_slot;
      logic                            batch_end;
   } result_type;

   entry_type                      head;
   logic                           clr_busy_ff, clr_busy_in;
   logic [BLOCK_W-1:0]             clr_row_ff, clr_row_in;
   logic                           s1_valid_ff;
   entry_type                      s1_entry_ff;
   logic [BLOCK_W-1:0]             waddr;
   logic [htbp_pkg::STATUS_W-1:0]  st_wdata;
   logic [GROUP_ID_WIDTH-1:0]      grp_wdata;
   logic [htbp_pkg::STATUS_W-1:0]  st_rd  [htbp_pkg::SLOTS];
   logic [GROUP_ID_WIDTH-1:0]      grp_rd [htbp_pkg::SLOTS];
   logic [htbp_pkg::SLOTS-1:0]     slot_we;
   logic [htbp_pkg::SLOTS-1:0]     hit;
   logic [htbp_pkg::SLOTS-1:0]     match;
   logic [3:0]                     first;
   result_type                     result;

   result_type                     ofifo_ff [htbp_pkg::OFIFO_DEPTH];
   logic [OPW-1:0]                 owr_ptr_ff, owr_ptr_in;
   logic [OPW-1:0]                 ord_ptr_ff, ord_ptr_in;
   logic [OCW-1:0]                 ocount_ff, ocount_in;
   logic                           opop;

   assign head = entry_type'(q_data);

   // clearing pass: one row of all eight slots per cycle after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (clr_busy_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == BLOCK_W'(ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_row_ff  <= clr_row_in;
      end
   end

   assign clr_busy = clr_busy_ff;

   // take a word only when the result buffer has room for everything in flight
   assign pop = !q_stat.empty && !clr_busy_ff &&
                (({1'b0, ocount_ff} + (OCW + 1)'(s1_valid_ff)) <
                 (OCW + 1)'(htbp_pkg::OFIFO_DEPTH));

   assign waddr     = clr_busy_ff ? clr_row_ff : head.row;
   assign st_wdata  = clr_busy_ff ? htbp_pkg::EMPTY_MARK : head.key;
   assign grp_wdata = clr_busy_ff ? '0 : head.grp;

   for (genvar i = 0; i < htbp_pkg::SLOTS; i++) begin : g_slot
      assign slot_we[i] = clr_busy_ff ||
                          (pop && head.op == htbp_pkg::OP_WRITE &&
                           head.slot == htbp_pkg::SLOT_W'(i));

      htbp_ram #(
         .WIDTH (htbp_pkg::STATUS_W),
         .DEPTH (ROWS)
      ) u_status_ram (
         .clock (clock),
         .we    (slot_we[i]),
         .waddr (waddr),
         .wdata (st_wdata),
         .raddr (head.row),
         .rdata (st_rd[i])
      );

      htbp_ram #(
         .WIDTH (GROUP_ID_WIDTH),
         .DEPTH (ROWS)
      ) u_group_ram (
         .clock (clock),
         .we    (slot_we[i]),
         .waddr (waddr),
         .wdata (grp_wdata),
         .raddr (head.row),
         .rdata (grp_rd[i])
      );
   end

   // compare stage, lined up with the registered ram read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_entry_ff <= head;
      end
   end

   always_comb begin
      for (int i = 0; i < htbp_pkg::SLOTS; i++) begin
         match[i] = (st_rd[i] == s1_entry_ff.key);
         hit[i]   = match[i] || (st_rd[i] == htbp_pkg::EMPTY_MARK);
      end
      // lowest hit wins, eight when the block has none
      first = 4'(htbp_pkg::SLOTS);
      for (int i = htbp_pkg::SLOTS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            first = 4'(i);
         end
      end

      result.batch_end = s1_entry_ff.last;
      if (s1_entry_ff.op == htbp_pkg::OP_WRITE) begin
         result.match_found = 1'b0;
         result.group_id    = '0;
         result.next_slot   = '0;
      end else begin
         result.match_found = |match;
         result.group_id    = grp_rd[first[htbp_pkg::SLOT_W-1:0]];
         result.next_slot   = {1'b0, s1_entry_ff.row, 3'b000} + NEXT_W'(first) +
                              NEXT_W'(|match);
      end
   end

   // result buffer in front of the response port
   assign opop = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      owr_ptr_in = owr_ptr_ff;
      ord_ptr_in = ord_ptr_ff;
      ocount_in  = ocount_ff;
      if (s1_valid_ff) begin
         owr_ptr_in = (owr_ptr_ff == OPW'(htbp_pkg::OFIFO_DEPTH - 1)) ? '0
                                                                   : owr_ptr_ff + 1'b1;
      end
      if (opop) begin
         ord_ptr_in = (ord_ptr_ff == OPW'(htbp_pkg::OFIFO_DEPTH - 1)) ? '0
                                                                   : ord_ptr_ff + 1'b1;
      end
      if (s1_valid_ff && !opop) begin
         ocount_in = ocount_ff + 1'b1;
      end else if (opop && !s1_valid_ff) begin
         ocount_in = ocount_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ptr_ff <= '0;
         ord_ptr_ff <= '0;
         ocount_ff  <= '0;
      end else begin
         owr_ptr_ff <= owr_ptr_in;
         ord_ptr_ff <= ord_ptr_in;
         ocount_ff  <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         ofifo_ff[owr_ptr_ff] <= result;
      end
   end

   assign rsp_bus.valid       = (ocount_ff != '0);
   assign rsp_bus.match_found = ofifo_ff[ord_ptr_ff].match_found;
   assign rsp_bus.group_id    = ofifo_ff[ord_ptr_ff].group_id;
   assign rsp_bus.next_slot   = ofifo_ff[ord_ptr_ff].next_slot;
   assign rsp_bus.batch_end   = ofifo_ff[ord_ptr_ff].batch_end;
endmodule

// ===== design/hash_table_block_probe.sv =====
// hash_table_block_probe: top level of the block-probe hash table lookup
// depends on htbp_pkg, htbp_ifs, htbp_front, htbp_queue, htbp_back
//
//  channel   | dir | handshake       | word
//  ----------+-----+-----------------+------------------------------------------------
//  req_bus   | in  | valid / ready   | cmd, hash, block_index, slot_index, slot_status,
//            |     |                 | group_value, last_in_batch
//  rsp_bus   | out | valid / ready   | match_found, group_id, next_slot, batch_end
//  csr_bus   | in  | valid / ready   | index, data (0 log_blocks, 1 stamp_bits)
//
// one request word per cycle while req_bus.ready is high, lookups and slot writes alike;
// every word gives one response word
// a request passes through decode and queue push, block read of all eight slot memories
// and compare into the result buffer before its response is valid
// after reset the slot memories are cleared one block per cycle, every block of the table,
// with req_bus.ready low; register writes are taken throughout
// a stalled response side fills the result buffer and then the queue before
// req_bus.ready drops
module hash_table_block_probe #(
   parameter int LOG_BLOCKS_MAX = htbp_pkg::LOG_BLOCKS_MAX_DEF,
   parameter int GROUP_ID_WIDTH = htbp_pkg::GROUP_ID_WIDTH_DEF,
   parameter int HASH_BITS      = htbp_pkg::HASH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   htbp_req_if.sink    req_bus,
   htbp_rsp_if.source  rsp_bus,
   htbp_csr_if.sink    csr_bus
);
   localparam int BLOCK_W     = htbp_pkg::block_width(LOG_BLOCKS_MAX);
   localparam int ENTRY_W     = htbp_pkg::entry_width(BLOCK_W, GROUP_ID_WIDTH);
   localparam int NEXT_SLOT_W = BLOCK_W + 4;

   // decoded words between the two halves
   logic                 push;
   logic [ENTRY_W-1:0]   push_data;
   logic                 pop;
   logic [ENTRY_W-1:0]   pop_data;
   htbp_pkg::qstat_type  q_stat;
   // memory clear still running
   logic                 clr_busy;

   // front: registers, accept and hash split
   htbp_front #(
      .LOG_BLOCKS_MAX (LOG_BLOCKS_MAX),
      .GROUP_ID_WIDTH (GROUP_ID_WIDTH),
      .HASH_BITS      (HASH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_bus   (csr_bus),
      .q_stat    (q_stat),
      .clr_busy  (clr_busy),
      .push      (push),
      .push_data (push_data)
   );

   // queue lets the front keep taking words while the back waits on rsp_bus
   htbp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (htbp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   // back: slot memories, eight-way compare, result buffer
   htbp_back #(
      .LOG_BLOCKS_MAX (LOG_BLOCKS_MAX),
      .GROUP_ID_WIDTH (GROUP_ID_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .q_data   (pop_data),
      .pop      (pop),
      .clr_busy (clr_busy),
      .rsp_bus  (rsp_bus)
   );
endmodule

// ===== design/htbp_checker.sv =====
// htbp_checker: port level checks of the hash table block probe, bound to the top
// depends on htbp_pkg; attaches to hash_table_block_probe
module htbp_checker #(
   parameter int GROUP_ID_WIDTH = htbp_pkg::GROUP_ID_WIDTH_DEF,
   parameter int NEXT_SLOT_W    = htbp_pkg::LOG_BLOCKS_MAX_DEF + 4
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_match_found,
   input logic [GROUP_ID_WIDTH-1:0] rsp_group_id,
   input logic [NEXT_SLOT_W-1:0]    rsp_next_slot,
   input logic                      rsp_batch_end
);
   localparam int CAP = htbp_pkg::QUEUE_DEPTH + htbp_pkg::OFIFO_DEPTH;
   localparam int OW  = $clog2(CAP + 2);

   logic [OW-1:0] outstanding_ff, outstanding_in;

   always_comb begin
      outstanding_in = outstanding_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // memory clear holds off requests right after reset
   a_clear_blocks_req: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during memory clear");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_match_found) && $stable(rsp_group_id) &&
                                  $stable(rsp_next_slot) && $stable(rsp_batch_end))
      else $error("response word changed while stalled");

   // every response belongs to an accepted request
   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != '0)
      else $error("response without pending request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OW'(CAP))
      else $error("more words in flight than buffering allows");
endmodule

bind hash_table_block_probe htbp_checker #(
   .GROUP_ID_WIDTH (GROUP_ID_WIDTH),
   .NEXT_SLOT_W    (NEXT_SLOT_W)
) u_htbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_match_found (rsp_bus.match_found),
   .rsp_group_id    (rsp_bus.group_id),
   .rsp_next_slot   (rsp_bus.next_slot),
   .rsp_batch_end   (rsp_bus.batch_end)
);

// ===== test/tb_hash_table_block_probe.sv =====
// tb_hash_table_block_probe: self-checking testbench of the block-probe hash table lookup
// needs htbp_pkg, the htbp channel interfaces and hash_table_block_probe from the design
// a local table model predicts every response word, which is checked in order
`timescale 1ns / 100ps

module tb_hash_table_block_probe;
   import htbp_pkg::*;

   localparam int LOG_BLOCKS_MAX = LOG_BLOCKS_MAX_DEF;
   localparam int GROUP_W        = GROUP_ID_WIDTH_DEF;
   localparam int HASH_BITS      = HASH_BITS_DEF;
   localparam int BLOCK_W        = block_width(LOG_BLOCKS_MAX);
   localparam int NEXT_W         = BLOCK_W + 4;
   localparam int TABLE_DEPTH    = (1 << LOG_BLOCKS_MAX) * SLOTS;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int PHASES         = 7;
   localparam int WORDS_PER_PHASE = 145;

   // one request word as the driver holds it
   typedef struct {
      op_type                  cmd;
      logic [HASH_WIDTH-1:0]   hash;
      logic [BLOCK_W-1:0]      block_index;
      logic [SLOT_W-1:0]       slot_index;
      logic [STATUS_W-1:0]     slot_status;
      logic [GROUP_W-1:0]      group_value;
      logic                    last_in_batch;
   } probe_req_t;

   // one response word
   typedef struct {
      logic                    match_found;
      logic [GROUP_W-1:0]      group_id;
      logic [NEXT_W-1:0]       next_slot;
      logic                    batch_end;
   } probe_rsp_t;

   logic clock = 1'b0;
   logic reset;

   htbp_req_if req_bus ();
   htbp_rsp_if rsp_bus ();
   htbp_csr_if csr_bus ();

   hash_table_block_probe DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   // local copy of the slot table and of the two registers
   logic [STATUS_W-1:0]         status_store [0:TABLE_DEPTH-1];
   logic [GROUP_W-1:0]          group_store  [0:TABLE_DEPTH-1];
   logic [LOG_BLOCKS_CFG_W-1:0] cfg_log_blocks;
   logic [STAMP_BITS_CFG_W-1:0] cfg_stamp_bits;

   probe_req_t pending_words [$];   // words still to be offered on req_bus
   probe_rsp_t expected_rsp  [$];   // predicted responses, oldest first
   int         error_count = 0;
   int         cycle_count = 0;

   // driver state
   probe_req_t held_word;
   int         burst_left = 0;
   int         gap_left   = 0;

   // receiver stall pattern state
   int         rsp_mode      = 0;
   int         rsp_mode_left = 0;
   logic       rsp_ready_next;
   probe_rsp_t want_rsp;

   // block count saturates at the table size
   function automatic int unsigned eff_log_blocks();
      return (cfg_log_blocks > LOG_BLOCKS_MAX) ? LOG_BLOCKS_MAX : cfg_log_blocks;
   endfunction

   // applies one accepted request word to the table model, returns its response
   function automatic probe_rsp_t table_response(input probe_req_t w);
      probe_rsp_t          r;
      int unsigned         lb, sb, used, shift, first, i;
      logic [31:0]         v;
      logic [STATUS_W-1:0] stamp, st;
      logic [BLOCK_W-1:0]  blk;
      logic [12:0]         base;
      logic                hit;
      r.batch_end = w.last_in_batch;
      if (w.cmd == OP_WRITE) begin
         // slot write: store and answer with zero fields
         status_store[{w.block_index, w.slot_index}] = w.slot_status;
         group_store[{w.block_index, w.slot_index}]  = w.group_value;
         r.match_found = 1'b0;
         r.group_id    = '0;
         r.next_slot   = '0;
         return r;
      end
      lb    = eff_log_blocks();
      sb    = cfg_stamp_bits;
      used  = lb + sb;
      shift = (used > HASH_BITS) ? 0 : HASH_BITS - used;
      v     = w.hash >> shift;
      stamp = 8'(v & ((32'd1 << sb) - 1));
      blk   = BLOCK_W'((v >> sb) & ((32'd1 << lb) - 1));
      base  = {blk, 3'b000};
      first = SLOTS;
      hit   = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         st = status_store[base + 13'(i)];
         if (st == stamp)
            hit = 1'b1;
         if ((st == stamp || st == EMPTY_MARK) && first == SLOTS)
            first = i;
      end
      r.match_found = hit;
      // full block with no match reads the group of slot 0
      r.group_id    = group_store[base + 13'(first % SLOTS)];
      r.next_slot   = NEXT_W'(blk * SLOTS + first + hit);
      return r;
   endfunction

   function automatic probe_req_t make_lookup(input logic [31:0] hash, input logic last);
      probe_req_t w;
      w.cmd           = OP_LOOKUP;
      w.hash          = hash;
      w.block_index   = BLOCK_W'($urandom);
      w.slot_index    = SLOT_W'($urandom);
      w.slot_status   = STATUS_W'($urandom);
      w.group_value   = GROUP_W'($urandom);
      w.last_in_batch = last;
      return w;
   endfunction

   function automatic probe_req_t make_write(input logic [BLOCK_W-1:0] blk,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [STATUS_W-1:0] status,
                                             input logic [GROUP_W-1:0] group,
                                             input logic last);
      probe_req_t w;
      w.cmd           = OP_WRITE;
      w.hash          = $urandom;
      w.block_index   = blk;
      w.slot_index    = slot;
      w.slot_status   = status;
      w.group_value   = group;
      w.last_in_batch = last;
      return w;
   endfunction

   // builds a hash that lands on a given block and stamp under the current registers
   function automatic logic [31:0] aimed_hash(input logic [BLOCK_W-1:0] blk,
                                              input logic [6:0] stamp);
      int unsigned lb, sb, shift;
      logic [63:0] field, noise;
      lb    = eff_log_blocks();
      sb    = cfg_stamp_bits;
      shift = HASH_BITS - lb - sb;
      field = ((64'(blk) & ((64'd1 << lb) - 1)) << sb) | (64'(stamp) & ((64'd1 << sb) - 1));
      noise = {$urandom, $urandom} & ((64'd1 << shift) - 1);
      return 32'((field << shift) | noise);
   endfunction

   // one random word, mostly aimed at a few busy blocks so they fill up
   task automatic push_random_word();
      int unsigned         nblk, sb;
      logic [BLOCK_W-1:0]  blk;
      logic [STATUS_W-1:0] status;
      logic [6:0]          stamp;
      nblk = 1 << eff_log_blocks();
      sb   = cfg_stamp_bits;
      if ($urandom_range(0, 9) < 6)
         blk = $urandom_range(0, ((nblk > 8) ? 8 : nblk) - 1);
      else
         blk = $urandom_range(0, nblk - 1);
      if ($urandom_range(0, 99) < 35) begin
         case ($urandom_range(0, 3))
            0, 1: status = $urandom_range(0, (1 << sb) - 1);
            2: status = EMPTY_MARK;
            default: status = STATUS_W'($urandom);
         endcase
         // some writes land anywhere in the table, also outside the blocks in use
         if ($urandom_range(0, 4) == 0)
            blk = BLOCK_W'($urandom);
         pending_words.push_back(make_write(blk, SLOT_W'($urandom), status,
                                            GROUP_W'($urandom), 1'($urandom)));
      end else if ($urandom_range(0, 4) == 0) begin
         pending_words.push_back(make_lookup($urandom, 1'($urandom)));
      end else begin
         // half the aimed lookups reuse a stamp already stored in the block
         if ($urandom_range(0, 1) == 0)
            stamp = 7'(status_store[{blk, SLOT_W'($urandom)}] & ((1 << sb) - 1));
         else
            stamp = $urandom_range(0, (1 << sb) - 1);
         pending_words.push_back(make_lookup(aimed_hash(blk, stamp), 1'($urandom)));
      end
   endtask

   // register write, only called while the block is idle
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      // word taken at this edge
      if (idx == CSR_LOG_BLOCKS)
         cfg_log_blocks = val;
      else if (idx == CSR_STAMP_BITS)
         cfg_stamp_bits = STAMP_BITS_CFG_W'(val);
      csr_bus.valid <= 1'b0;
   endtask

   // every offered word taken and every response seen
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_words.size() != 0 || req_bus.valid || expected_rsp.size() != 0);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: rsp %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // request driver: bursts of random length with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         // a word accepted at this edge goes through the model in stream order
         if (req_bus.valid && req_bus.ready)
            expected_rsp.push_back(table_response(held_word));
         if (!req_bus.valid || req_bus.ready) begin
            if (burst_left == 0) begin
               // now and then a long stretch with no idling at all
               if ($urandom_range(0, 9) == 0) begin
                  burst_left = $urandom_range(100, 300);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
               end
            end
            if (gap_left > 0 || pending_words.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_bus.valid <= 1'b0;
            end else begin
               held_word = pending_words.pop_front();
               req_bus.cmd           <= held_word.cmd;
               req_bus.hash          <= held_word.hash;
               req_bus.block_index   <= held_word.block_index;
               req_bus.slot_index    <= held_word.slot_index;
               req_bus.slot_status   <= held_word.slot_status;
               req_bus.group_value   <= held_word.group_value;
               req_bus.last_in_batch <= held_word.last_in_batch;
               req_bus.valid         <= 1'b1;
               burst_left--;
            end
         end
      end
   end

   // response monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: rsp word with none expected, actual match %0h group %0h next %0h end %0h",
                        $time, rsp_bus.match_found, rsp_bus.group_id, rsp_bus.next_slot,
                        rsp_bus.batch_end);
               error_count++;
            end else begin
               want_rsp = expected_rsp.pop_front();
               check_field("match_found", want_rsp.match_found, rsp_bus.match_found);
               check_field("group_id",    want_rsp.group_id,    rsp_bus.group_id);
               check_field("next_slot",   want_rsp.next_slot,   rsp_bus.next_slot);
               check_field("batch_end",   want_rsp.batch_end,   rsp_bus.batch_end);
            end
         end
         // modes: always ready, coin flip, mostly stalled
         if (rsp_mode_left == 0) begin
            rsp_mode      = $urandom_range(0, 2);
            rsp_mode_left = $urandom_range(20, 200);
         end
         rsp_mode_left--;
         case (rsp_mode)
            0: rsp_ready_next = 1'b1;
            1: rsp_ready_next = 1'($urandom_range(0, 1));
            default: rsp_ready_next = ($urandom_range(0, 7) == 0);
         endcase
         rsp_bus.ready <= rsp_ready_next;
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_hash_table_block_probe NOT OK");
      $finish;
   end

   // stimulus and end of run
   initial begin
      int                  p, n;
      int                  phase_lb [PHASES];
      int                  phase_sb [PHASES];
      phase_lb = '{10, 0, 3, 1, 6, 12, 10};
      phase_sb = '{7, 1, 3, 7, 2, 13, 0};

      // known values on every input from time zero
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = OP_LOOKUP;
      req_bus.hash          = '0;
      req_bus.block_index   = '0;
      req_bus.slot_index    = '0;
      req_bus.slot_status   = '0;
      req_bus.group_value   = '0;
      req_bus.last_in_batch = 1'b0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      for (n = 0; n < TABLE_DEPTH; n++) begin
         status_store[n] = EMPTY_MARK;
         group_store[n]  = '0;
      end
      cfg_log_blocks = LOG_BLOCKS_RESET;
      cfg_stamp_bits = STAMP_BITS_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset registers: one block, stamp is the top seven hash bits
      pending_words.push_back(make_lookup(32'h0000_0000, 1'b0));   // empty table
      pending_words.push_back(make_lookup(32'hFFFF_FFFF, 1'b1));
      pending_words.push_back(make_write(0, 0, 8'h7F, 25'h1FF_FFFF, 1'b0));
      pending_words.push_back(make_write(0, 1, EMPTY_MARK, 25'h155_5555, 1'b1));
      pending_words.push_back(make_write(0, 2, 8'h05, 25'h0AA_AAAA, 1'b0));
      // empty slot 1 ahead of the match in slot 2
      pending_words.push_back(make_lookup(32'h0BFF_FFFF, 1'b0));
      // match in slot 0
      pending_words.push_back(make_lookup(32'hFE00_0000, 1'b1));
      // fill block 0 with no empty slot left
      pending_words.push_back(make_write(0, 1, 8'h11, 25'h000_0011, 1'b0));
      pending_words.push_back(make_write(0, 3, 8'h20, 25'h000_0020, 1'b0));
      pending_words.push_back(make_write(0, 4, 8'h21, 25'h000_0021, 1'b1));
      pending_words.push_back(make_write(0, 5, 8'h00, 25'h000_0000, 1'b0));
      pending_words.push_back(make_write(0, 6, 8'hFF, 25'h0FF_FFFF, 1'b0));
      pending_words.push_back(make_write(0, 7, 8'h22, 25'h000_0022, 1'b0));
      // full block, no match
      pending_words.push_back(make_lookup(32'h6600_0000, 1'b0));
      // match in the last slot
      pending_words.push_back(make_lookup(32'h4400_0000, 1'b1));
      // last slot of the whole table
      pending_words.push_back(make_write(10'h3FF, 7, 8'hFF, 25'h000_0000, 1'b1));
      pending_words.push_back(make_write(10'h3FF, 0, 8'h03, 25'h123_4567, 1'b0));
      wait_drained();

      // block count above the table saturates, stamp width of zero
      write_csr(CSR_LOG_BLOCKS, 4'd15);
      write_csr(CSR_STAMP_BITS, 4'd8);
      pending_words.push_back(make_lookup(32'hFFFF_FFFF, 1'b1));   // top block
      pending_words.push_back(make_lookup(32'h003F_FFFF, 1'b0));   // stamp 0 found in block 0
      pending_words.push_back(make_lookup(32'h0040_0000, 1'b0));   // untouched block 1
      pending_words.push_back(make_write(1, 3, 8'h00, 25'h0ABC_DEF, 1'b0));
      pending_words.push_back(make_lookup(32'h0040_0000, 1'b1));   // empty slot before match
      wait_drained();

      // random phases, each under its own register setting
      for (p = 0; p < PHASES; p++) begin
         write_csr(CSR_LOG_BLOCKS, CSR_DATA_W'(phase_lb[p]));
         write_csr(CSR_STAMP_BITS, CSR_DATA_W'(phase_sb[p]));
         // writes to indexes beyond the two registers must change nothing
         if (p % 2 == 1) begin
            write_csr(CSR_INDEX_W'(2), CSR_DATA_W'($urandom));
            write_csr(CSR_INDEX_W'(3), CSR_DATA_W'($urandom));
         end
         for (n = 0; n < WORDS_PER_PHASE; n++)
            push_random_word();
         wait_drained();
      end

      // allow for the pipeline to show any stray word
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb_hash_table_block_probe OK");
      else
         $display("tb_hash_table_block_probe NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
design/htbp_pkg.sv
design/htbp_ifs.sv
design/htbp_ram.sv
design/htbp_queue.sv
design/htbp_front.sv
design/htbp_back.sv
design/hash_table_block_probe.sv
design/htbp_checker.sv
test/tb_hash_table_block_probe.sv
